// ----- sv/v4alu_pkg.sv -----
`default_nettype none
package v4alu_pkg;

   localparam int WORD_W        = 32;
   localparam int LANES         = 4;
   localparam int FRAC_BITS_DEF = 16;
   localparam int ACC_W         = 2 * WORD_W + 2;

   // square root of the 64-bit sum of squares, two radicand bits per step
   localparam int RAD_W          = 2 * WORD_W;
   localparam int ROOT_W         = WORD_W;
   localparam int REM_W          = ROOT_W + 1;
   localparam int SQRT_PER_STAGE = 4;
   localparam int SQRT_STAGES    = (ROOT_W + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

   // restoring divide, one quotient bit per step
   localparam int QUOT_W        = WORD_W + 1;
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = (QUOT_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

   localparam logic [3:0] FUNC_ADD   = 4'd0;
   localparam logic [3:0] FUNC_SUB   = 4'd1;
   localparam logic [3:0] FUNC_SCALE = 4'd2;
   localparam logic [3:0] FUNC_DIV   = 4'd3;
   localparam logic [3:0] FUNC_DOT   = 4'd4;
   localparam logic [3:0] FUNC_MAG   = 4'd5;
   localparam logic [3:0] FUNC_NORM  = 4'd6;
   localparam logic [3:0] FUNC_EQ    = 4'd7;
   localparam logic [3:0] FUNC_NEAR  = 4'd8;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   // results settled early plus operands the divider still needs
   typedef struct packed {
      logic [3:0]                    func;
      logic [LANES-1:0][WORD_W-1:0]  vec;
      logic [WORD_W-1:0]             scal;
      logic                          flag;
      logic                          sat;
      logic [LANES-1:0][WORD_W-1:0]  a_mag;
      logic [LANES-1:0]              a_neg;
      logic [WORD_W-1:0]             s_mag;
      logic                          s_neg;
   } side_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic              big;
   } sq_type;

   typedef struct packed {
      logic [LANES-1:0][QUOT_W-1:0] rem;
      logic [LANES-1:0][QUOT_W-1:0] quot;
      logic [LANES-1:0][QUOT_W-1:0] nlo;
      logic [LANES-1:0]             ovf;
      logic [QUOT_W-1:0]            dvs;
      logic [QUOT_W-1:0]            mag;
   } dv_type;

endpackage
`default_nettype wire

// ----- sv/v4alu_ifs.sv -----
`default_nettype none
interface v4alu_req_if;
   import v4alu_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [3:0]               func;
   logic signed [WORD_W-1:0] a_x;
   logic signed [WORD_W-1:0] a_y;
   logic signed [WORD_W-1:0] a_z;
   logic signed [WORD_W-1:0] a_w;
   logic signed [WORD_W-1:0] b_x;
   logic signed [WORD_W-1:0] b_y;
   logic signed [WORD_W-1:0] b_z;
   logic signed [WORD_W-1:0] b_w;
   logic signed [WORD_W-1:0] scalar_in;

   modport source (output valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
                   input ready);
   modport sink   (input valid, func, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in,
                   output ready);
endinterface

interface v4alu_rsp_if;
   import v4alu_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] r_x;
   logic signed [WORD_W-1:0] r_y;
   logic signed [WORD_W-1:0] r_z;
   logic signed [WORD_W-1:0] r_w;
   logic signed [WORD_W-1:0] r_scalar;
   logic                     r_flag;
   logic [1:0]               r_status;

   modport source (output valid, r_x, r_y, r_z, r_w, r_scalar, r_flag, r_status,
                   input ready);
   modport sink   (input valid, r_x, r_y, r_z, r_w, r_scalar, r_flag, r_status,
                   output ready);
endinterface
`default_nettype wire

// ----- sv/v4alu_front.sv -----
`default_nettype none
module v4alu_front #(
   parameter int FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            en,
   input  logic                                            in_valid,
   input  logic [3:0]                                      in_func,
   input  logic [v4alu_pkg::LANES-1:0][v4alu_pkg::WORD_W-1:0] in_a,
   input  logic [v4alu_pkg::LANES-1:0][v4alu_pkg::WORD_W-1:0] in_b,
   input  logic [v4alu_pkg::WORD_W-1:0]                    in_s,
   output logic                                            out_valid,
   output v4alu_pkg::side_type                             out_side,
   output v4alu_pkg::sq_type                               out_sq
);
   import v4alu_pkg::*;

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

   // {saturated, clamped word}
   function automatic logic [WORD_W:0] sat_word(input logic [ACC_W-1:0] v);
      logic ovf;
      ovf = !((&v[ACC_W-1:WORD_W-1]) || !(|v[ACC_W-1:WORD_W-1]));
      return {ovf, ovf ? {v[ACC_W-1], {(WORD_W-1){~v[ACC_W-1]}}} : v[WORD_W-1:0]};
   endfunction

   // stage 1: multiply, add/sub, compares
   logic [LANES-1:0][WORD_W-1:0] opnd;
   logic signed [2*WORD_W-1:0]   prod_in [LANES];
   logic signed [WORD_W:0]       dif [LANES];
   logic signed [WORD_W:0]       addsub [LANES];
   logic [WORD_W:0]              dmag [LANES];
   logic [LANES-1:0]             eq_l, near_l, as_sat;
   logic [LANES-1:0][WORD_W-1:0] as_val;
   side_type                     side1_in;

   logic                         valid1_ff;
   side_type                     side1_ff;
   logic signed [2*WORD_W-1:0]   prod1_ff [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         priority if (in_func == FUNC_SCALE) begin
            opnd[i] = in_s;
         end else if (in_func == FUNC_DOT) begin
            opnd[i] = in_b[i];
         end else begin
            opnd[i] = in_a[i];
         end
         prod_in[i] = $signed(in_a[i]) * $signed(opnd[i]);
         dif[i] = $signed({in_a[i][WORD_W-1], in_a[i]}) - $signed({in_b[i][WORD_W-1], in_b[i]});
         addsub[i] = (in_func == FUNC_SUB) ? dif[i] :
                     $signed({in_a[i][WORD_W-1], in_a[i]}) + $signed({in_b[i][WORD_W-1], in_b[i]});
         as_sat[i] = addsub[i][WORD_W] != addsub[i][WORD_W-1];
         as_val[i] = as_sat[i] ? {addsub[i][WORD_W], {(WORD_W-1){~addsub[i][WORD_W]}}}
                               : addsub[i][WORD_W-1:0];
         dmag[i] = dif[i][WORD_W] ? -dif[i] : dif[i];
         eq_l[i] = in_a[i] == in_b[i];
         near_l[i] = !in_s[WORD_W-1] && ({1'b0, dmag[i]} < {2'b00, in_s});
      end

      side1_in = '0;
      side1_in.func = in_func;
      if (in_func == FUNC_ADD || in_func == FUNC_SUB) begin
         side1_in.vec = as_val;
         side1_in.sat = |as_sat;
      end
      if (in_func == FUNC_EQ) begin
         side1_in.flag = &eq_l;
      end else if (in_func == FUNC_NEAR) begin
         side1_in.flag = &near_l;
      end
      for (int i = 0; i < LANES; i++) begin
         side1_in.a_neg[i] = in_a[i][WORD_W-1];
         side1_in.a_mag[i] = in_a[i][WORD_W-1] ? -in_a[i] : in_a[i];
      end
      side1_in.s_neg = in_s[WORD_W-1];
      side1_in.s_mag = in_s[WORD_W-1] ? -in_s : in_s;
   end

   // stage 2: scale rounding, pairwise sums
   logic signed [ACC_W-1:0] sc_t [LANES];
   logic [WORD_W:0]         sc_w [LANES];
   logic [LANES-1:0]        sc_sat;
   side_type                side2_in;
   logic signed [ACC_W-1:0] pr2_in [2];

   logic                    valid2_ff;
   side_type                side2_ff;
   logic signed [ACC_W-1:0] pr2_ff [2];

   always_comb begin
      side2_in = side1_ff;
      for (int i = 0; i < LANES; i++) begin
         sc_t[i] = ACC_W'(prod1_ff[i]) + HALF;
         sc_w[i] = sat_word(sc_t[i] >>> FRAC_BITS);
         sc_sat[i] = sc_w[i][WORD_W];
      end
      if (side1_ff.func == FUNC_SCALE) begin
         for (int i = 0; i < LANES; i++) begin
            side2_in.vec[i] = sc_w[i][WORD_W-1:0];
         end
         side2_in.sat = |sc_sat;
      end
      pr2_in[0] = ACC_W'(prod1_ff[0]) + ACC_W'(prod1_ff[1]);
      pr2_in[1] = ACC_W'(prod1_ff[2]) + ACC_W'(prod1_ff[3]);
   end

   // stage 3: full sum of products
   logic                    valid3_ff;
   side_type                side3_ff;
   logic signed [ACC_W-1:0] sum3_ff;

   // stage 4: dot rounding, radicand for the root
   logic signed [ACC_W-1:0] dot_t;
   logic [WORD_W:0]         dot_w;
   side_type                side4_in;
   sq_type                  sq4_in;

   always_comb begin
      dot_t = sum3_ff + HALF;
      dot_w = sat_word(dot_t >>> FRAC_BITS);
      side4_in = side3_ff;
      if (side3_ff.func == FUNC_DOT) begin
         side4_in.scal = dot_w[WORD_W-1:0];
         side4_in.sat  = dot_w[WORD_W];
      end
      sq4_in      = '0;
      sq4_in.rad  = sum3_ff[RAD_W-1:0];
      sq4_in.big  = sum3_ff[RAD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         out_valid <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         out_valid <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         for (int i = 0; i < LANES; i++) begin
            prod1_ff[i] <= prod_in[i];
         end
         side2_ff <= side2_in;
         pr2_ff[0] <= pr2_in[0];
         pr2_ff[1] <= pr2_in[1];
         side3_ff <= side2_ff;
         sum3_ff  <= pr2_ff[0] + pr2_ff[1];
         out_side <= side4_in;
         out_sq   <= sq4_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/v4alu_sqrt_stage.sv -----
`default_nettype none
module v4alu_sqrt_stage #(
   parameter int STEPS = v4alu_pkg::SQRT_PER_STAGE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  v4alu_pkg::side_type in_side,
   input  v4alu_pkg::sq_type   in_sq,
   output logic                out_valid,
   output v4alu_pkg::side_type out_side,
   output v4alu_pkg::sq_type   out_sq
);
   import v4alu_pkg::*;

   sq_type             stp [STEPS+1];
   logic [REM_W+1:0]   rem_n [STEPS];
   logic [REM_W+1:0]   trial [STEPS];
   sq_type             sq_in;

   always_comb begin
      stp[0] = in_sq;
      for (int k = 0; k < STEPS; k++) begin
         rem_n[k] = {stp[k].rem, stp[k].rad[RAD_W-1 -: 2]};
         trial[k] = (REM_W+2)'({stp[k].root, 2'b01});
         stp[k+1] = stp[k];
         stp[k+1].rad = {stp[k].rad[RAD_W-3:0], 2'b00};
         if (rem_n[k] >= trial[k]) begin
            stp[k+1].rem  = REM_W'(rem_n[k] - trial[k]);
            stp[k+1].root = {stp[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            stp[k+1].rem  = rem_n[k][REM_W-1:0];
            stp[k+1].root = {stp[k].root[ROOT_W-2:0], 1'b0};
         end
      end
      sq_in = stp[STEPS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_side <= in_side;
         out_sq   <= sq_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/v4alu_div_stage.sv -----
`default_nettype none
module v4alu_div_stage #(
   parameter int STEPS = v4alu_pkg::DIV_PER_STAGE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  v4alu_pkg::side_type in_side,
   input  v4alu_pkg::dv_type   in_dv,
   output logic                out_valid,
   output v4alu_pkg::side_type out_side,
   output v4alu_pkg::dv_type   out_dv
);
   import v4alu_pkg::*;

   dv_type          stp [STEPS+1];
   logic [QUOT_W:0] rn [STEPS][LANES];
   dv_type          dv_in;

   always_comb begin
      stp[0] = in_dv;
      for (int k = 0; k < STEPS; k++) begin
         stp[k+1] = stp[k];
         for (int l = 0; l < LANES; l++) begin
            rn[k][l] = {stp[k].rem[l], stp[k].nlo[l][QUOT_W-1]};
            stp[k+1].nlo[l] = {stp[k].nlo[l][QUOT_W-2:0], 1'b0};
            if (rn[k][l] >= {1'b0, stp[k].dvs}) begin
               stp[k+1].rem[l]  = QUOT_W'(rn[k][l] - {1'b0, stp[k].dvs});
               stp[k+1].quot[l] = {stp[k].quot[l][QUOT_W-2:0], 1'b1};
            end else begin
               stp[k+1].rem[l]  = rn[k][l][QUOT_W-1:0];
               stp[k+1].quot[l] = {stp[k].quot[l][QUOT_W-2:0], 1'b0};
            end
         end
      end
      dv_in = stp[STEPS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_side <= in_side;
         out_dv   <= dv_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/vector4_alu_core.sv -----
// A req_ch beat passes 4 multiply/sum stages, 8 root stages, 1 divide setup,
// 9 divide stages and 1 output register on its way to the rsp_ch beat.
// Throughput: one beat per cycle; divider and root retire up to 4 bits per stage.
// Back-pressure on rsp_ch freezes the whole pipe in place.
// Reset (synchronous, active high) clears every valid bit; data regs are not reset.
`default_nettype none
module vector4_alu_core #(
   parameter int FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   v4alu_req_if.sink    req_ch,
   v4alu_rsp_if.source  rsp_ch
);
   import v4alu_pkg::*;

   localparam int NUM_W = WORD_W + FRAC_BITS;

   // single advance for every stage: move unless the output beat is held
   logic adv;
   logic rsp_valid_ff;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // front end: multipliers, add/sub, compares, dot rounding
   logic [LANES-1:0][WORD_W-1:0] in_a, in_b;
   assign in_a = {req_ch.a_w, req_ch.a_z, req_ch.a_y, req_ch.a_x};
   assign in_b = {req_ch.b_w, req_ch.b_z, req_ch.b_y, req_ch.b_x};

   logic     sq_valid [SQRT_STAGES+1];
   side_type sq_side  [SQRT_STAGES+1];
   sq_type   sq_st    [SQRT_STAGES+1];

   v4alu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_ch.valid),
      .in_func   (req_ch.func),
      .in_a      (in_a),
      .in_b      (in_b),
      .in_s      (req_ch.scalar_in),
      .out_valid (sq_valid[0]),
      .out_side  (sq_side[0]),
      .out_sq    (sq_st[0])
   );

   // root of the sum of squares
   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      localparam int LEFT    = ROOT_W - g * SQRT_PER_STAGE;
      localparam int STEPS_G = (LEFT < SQRT_PER_STAGE) ? LEFT : SQRT_PER_STAGE;
      v4alu_sqrt_stage #(.STEPS(STEPS_G)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (sq_valid[g]),
         .in_side   (sq_side[g]),
         .in_sq     (sq_st[g]),
         .out_valid (sq_valid[g+1]),
         .out_side  (sq_side[g+1]),
         .out_sq    (sq_st[g+1])
      );
   end

   // divide setup: pick divisor, pre-load the high dividend bits, catch
   // quotients of 2^33 and above up front
   logic [QUOT_W-1:0] mag_c, dvs_c;
   logic [NUM_W-1:0]  num_c [LANES];
   dv_type            pre_in;

   logic     dv_valid [DIV_STAGES+1];
   side_type dv_side  [DIV_STAGES+1];
   dv_type   dv_st    [DIV_STAGES+1];

   always_comb begin
      mag_c = sq_st[SQRT_STAGES].big ? QUOT_W'({1'b1, ROOT_W'(0)})
                                     : QUOT_W'(sq_st[SQRT_STAGES].root);
      dvs_c = (sq_side[SQRT_STAGES].func == FUNC_DIV) ? QUOT_W'(sq_side[SQRT_STAGES].s_mag)
                                                      : mag_c;
      pre_in = '0;
      pre_in.dvs = dvs_c;
      pre_in.mag = mag_c;
      for (int l = 0; l < LANES; l++) begin
         num_c[l] = {sq_side[SQRT_STAGES].a_mag[l], FRAC_BITS'(0)};
         pre_in.rem[l] = QUOT_W'(num_c[l][NUM_W-1:QUOT_W]);
         pre_in.ovf[l] = pre_in.rem[l] >= dvs_c;
         pre_in.nlo[l] = num_c[l][QUOT_W-1:0];
      end
   end

   logic     pre_valid_ff;
   side_type pre_side_ff;
   dv_type   pre_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (adv) begin
         pre_valid_ff <= sq_valid[SQRT_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_side_ff <= sq_side[SQRT_STAGES];
         pre_dv_ff   <= pre_in;
      end
   end

   assign dv_valid[0] = pre_valid_ff;
   assign dv_side[0]  = pre_side_ff;
   assign dv_st[0]    = pre_dv_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      localparam int LEFT    = QUOT_W - g * DIV_PER_STAGE;
      localparam int STEPS_G = (LEFT < DIV_PER_STAGE) ? LEFT : DIV_PER_STAGE;
      v4alu_div_stage #(.STEPS(STEPS_G)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (dv_valid[g]),
         .in_side   (dv_side[g]),
         .in_dv     (dv_st[g]),
         .out_valid (dv_valid[g+1]),
         .out_side  (dv_side[g+1]),
         .out_dv    (dv_st[g+1])
      );
   end

   // output: sign and clamp quotients, select by operation
   side_type                     fs;
   dv_type                       fd;
   logic [LANES-1:0]             q_neg, q_sat;
   logic [LANES-1:0][WORD_W-1:0] q_val;
   logic [QUOT_W-1:0]            q;
   logic [LANES-1:0][WORD_W-1:0] vec_in;
   logic [WORD_W-1:0]            scal_in;
   logic                         flag_in;
   logic [1:0]                   status_in;

   always_comb begin
      fs = dv_side[DIV_STAGES];
      fd = dv_st[DIV_STAGES];
      for (int l = 0; l < LANES; l++) begin
         q = fd.quot[l];
         q_neg[l] = (fs.func == FUNC_DIV) ? (fs.a_neg[l] ^ fs.s_neg) : fs.a_neg[l];
         // negative side may reach exactly 2^31
         q_sat[l] = fd.ovf[l] || q[QUOT_W-1] ||
                    (q[WORD_W-1] && (!q_neg[l] || (|q[WORD_W-2:0])));
         if (q_sat[l]) begin
            q_val[l] = {q_neg[l], {(WORD_W-1){~q_neg[l]}}};
         end else begin
            q_val[l] = q_neg[l] ? -q[WORD_W-1:0] : q[WORD_W-1:0];
         end
      end

      vec_in    = '0;
      scal_in   = '0;
      flag_in   = 1'b0;
      status_in = ST_OK;
      unique case (fs.func)
         FUNC_ADD, FUNC_SUB, FUNC_SCALE: begin
            vec_in    = fs.vec;
            status_in = fs.sat ? ST_SAT : ST_OK;
         end
         FUNC_DIV: begin
            if (fs.s_mag == '0) begin
               status_in = ST_DIV0;
            end else begin
               vec_in    = q_val;
               status_in = (|q_sat) ? ST_SAT : ST_OK;
            end
         end
         FUNC_DOT: begin
            scal_in   = fs.scal;
            status_in = fs.sat ? ST_SAT : ST_OK;
         end
         FUNC_MAG: begin
            if (fd.mag[QUOT_W-1] || fd.mag[WORD_W-1]) begin
               scal_in   = {1'b0, {(WORD_W-1){1'b1}}};
               status_in = ST_SAT;
            end else begin
               scal_in = fd.mag[WORD_W-1:0];
            end
         end
         FUNC_NORM: begin
            // zero vector normalises to zero
            if (fd.mag != '0) begin
               vec_in    = q_val;
               status_in = (|q_sat) ? ST_SAT : ST_OK;
            end
         end
         FUNC_EQ, FUNC_NEAR: begin
            flag_in = fs.flag;
         end
         default: begin
         end
      endcase
   end

   logic [LANES-1:0][WORD_W-1:0] rsp_vec_ff;
   logic [WORD_W-1:0]            rsp_scal_ff;
   logic                         rsp_flag_ff;
   logic [1:0]                   rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_vec_ff    <= vec_in;
         rsp_scal_ff   <= scal_in;
         rsp_flag_ff   <= flag_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.r_x      = rsp_vec_ff[0];
   assign rsp_ch.r_y      = rsp_vec_ff[1];
   assign rsp_ch.r_z      = rsp_vec_ff[2];
   assign rsp_ch.r_w      = rsp_vec_ff[3];
   assign rsp_ch.r_scalar = rsp_scal_ff;
   assign rsp_ch.r_flag   = rsp_flag_ff;
   assign rsp_ch.r_status = rsp_status_ff;

   // a divide-by-zero beat carries nothing but its status
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.r_status == ST_DIV0) |->
      (rsp_ch.r_x == 0 && rsp_ch.r_y == 0 && rsp_ch.r_z == 0 && rsp_ch.r_w == 0 &&
       rsp_ch.r_scalar == 0 && !rsp_ch.r_flag))
      else $error("divide by zero beat with non-zero payload");

   // comparisons that set the flag never saturate and leave the numeric fields clear
   a_flag_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.r_flag) |->
      (rsp_ch.r_x == 0 && rsp_ch.r_y == 0 && rsp_ch.r_z == 0 && rsp_ch.r_w == 0 &&
       rsp_ch.r_scalar == 0 && rsp_ch.r_status == ST_OK))
      else $error("compare result mixed with arithmetic fields");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.r_status == ST_OK || rsp_ch.r_status == ST_DIV0 ||
                        rsp_ch.r_status == ST_SAT))
      else $error("undefined status code");

   // a stalled pipe must not move beats between stages
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (pre_valid_ff == $past(pre_valid_ff) &&
                dv_valid[DIV_STAGES] == $past(dv_valid[DIV_STAGES])))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import v4alu_pkg::*;

   // one result beat as the block presents it
   typedef struct {
      logic signed [31:0] vx, vy, vz, vw;
      logic signed [31:0] scal;
      logic               flag;
      logic [1:0]         status;
   } alu_result_type;

   // one request beat
   typedef struct {
      logic [3:0]         func;
      logic signed [31:0] a [4];
      logic signed [31:0] b [4];
      logic signed [31:0] s;
   } alu_op_type;

   localparam int FRAC      = FRAC_BITS_DEF;
   localparam int LATENCY   = 23;
   localparam int RAND_OPS  = 1850;
   localparam int WDOG_MAX  = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   v4alu_req_if req_ch ();
   v4alu_rsp_if rsp_ch ();

   vector4_alu_core #(.FRAC_BITS(FRAC)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   alu_result_type pending_results [$];
   int             error_count = 0;
   int             idle_cycles = 0;
   bit             calm        = 1'b0;   // no idling in the closing stretch

   // ---------------------------------------------------------------------
   // Predictor helpers
   // ---------------------------------------------------------------------

   // clamp to 32 bits, flag saturation
   function automatic logic signed [31:0] clamp32(input longint v, inout logic [1:0] st);
      if (v > 64'sd2147483647) begin
         st = ST_SAT;
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         st = ST_SAT;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // arithmetic shift right is a floor divide by 2^FRAC
   function automatic longint floor_frac(input longint v);
      return v >>> FRAC;
   endfunction

   // restoring square root of a 64-bit unsigned value
   function automatic longint unsigned root64(input longint unsigned n);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // expected result beat for one request beat
   function automatic alu_result_type predict_alu(input alu_op_type op);
      alu_result_type  r;
      logic [1:0]      st;
      longint          a [4], b [4], s, v, hi, hi_sum, lo_sum, p, d;
      longint          unity, half;
      longint unsigned sum, ns, m, mag;
      bit              carry;
      logic signed [31:0] vec [4];
      st    = ST_OK;
      unity = 64'sd1 <<< FRAC;
      half  = 64'sd1 <<< (FRAC - 1);
      s     = op.s;
      for (int i = 0; i < 4; i++) begin
         a[i]   = op.a[i];
         b[i]   = op.b[i];
         vec[i] = '0;
      end
      r.scal = '0;
      r.flag = 1'b0;
      case (op.func)
         FUNC_ADD, FUNC_SUB: begin
            for (int i = 0; i < 4; i++) begin
               v      = (op.func == FUNC_ADD) ? a[i] + b[i] : a[i] - b[i];
               vec[i] = clamp32(v, st);
            end
         end
         FUNC_SCALE: begin
            for (int i = 0; i < 4; i++) vec[i] = clamp32(floor_frac(a[i] * s + half), st);
         end
         FUNC_DIV: begin
            if (s == 0) st = ST_DIV0;
            else for (int i = 0; i < 4; i++) vec[i] = clamp32((a[i] * unity) / s, st);
         end
         FUNC_DOT: begin
            // split each product so the sum cannot overflow 64 bits
            hi_sum = 0;
            lo_sum = 0;
            for (int i = 0; i < 4; i++) begin
               p      = a[i] * b[i];
               hi     = floor_frac(p);
               hi_sum += hi;
               lo_sum += p - hi * unity;
            end
            r.scal = clamp32(hi_sum + floor_frac(lo_sum + half), st);
         end
         FUNC_MAG, FUNC_NORM: begin
            sum   = 0;
            carry = 1'b0;
            for (int i = 0; i < 4; i++) begin
               m  = (a[i] < 0) ? -a[i] : a[i];
               ns = sum + m * m;
               if (ns < sum) carry = 1'b1;
               sum = ns;
            end
            mag = carry ? 64'h1_0000_0000 : root64(sum);
            if (op.func == FUNC_MAG) r.scal = clamp32(longint'(mag), st);
            else if (mag != 0)
               for (int i = 0; i < 4; i++) vec[i] = clamp32((a[i] * unity) / longint'(mag), st);
         end
         FUNC_EQ: begin
            r.flag = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]) && (a[3] == b[3]);
         end
         FUNC_NEAR: begin
            r.flag = 1'b1;
            for (int i = 0; i < 4; i++) begin
               d = a[i] - b[i];
               if (d < 0) d = -d;
               if (!(d < s)) r.flag = 1'b0;
            end
         end
         default: ;
      endcase
      r.vx = vec[0];
      r.vy = vec[1];
      r.vz = vec[2];
      r.vw = vec[3];
      r.status = st;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // field-by-field compare of one beat
   task automatic compare_beat(input string who, input alu_result_type got,
                               input alu_result_type want);
      if (got.vx !== want.vx) report_mismatch({who, " r_x"}, got.vx, want.vx);
      if (got.vy !== want.vy) report_mismatch({who, " r_y"}, got.vy, want.vy);
      if (got.vz !== want.vz) report_mismatch({who, " r_z"}, got.vz, want.vz);
      if (got.vw !== want.vw) report_mismatch({who, " r_w"}, got.vw, want.vw);
      if (got.scal !== want.scal) report_mismatch({who, " r_scalar"}, got.scal, want.scal);
      if (got.flag !== want.flag) report_mismatch({who, " r_flag"}, got.flag, want.flag);
      if (got.status !== want.status)
         report_mismatch({who, " r_status"}, got.status, want.status);
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // directed rows; has_want marks those whose result is typed in
   typedef struct {
      alu_op_type     op;
      bit             has_want;
      alu_result_type want;
   } direct_row_type;

   direct_row_type directed [$];

   function automatic alu_op_type mk_op(input logic [3:0] f,
                                        input logic signed [31:0] a0, a1, a2, a3,
                                        input logic signed [31:0] b0, b1, b2, b3,
                                        input logic signed [31:0] s);
      alu_op_type o;
      o.func = f;
      o.a[0] = a0; o.a[1] = a1; o.a[2] = a2; o.a[3] = a3;
      o.b[0] = b0; o.b[1] = b1; o.b[2] = b2; o.b[3] = b3;
      o.s    = s;
      return o;
   endfunction

   function automatic alu_result_type mk_res(input logic signed [31:0] x, y, z, w, sc,
                                             input logic fl, input logic [1:0] st);
      alu_result_type r;
      r.vx = x; r.vy = y; r.vz = z; r.vw = w;
      r.scal = sc; r.flag = fl; r.status = st;
      return r;
   endfunction

   task automatic add_row(input alu_op_type op, input bit has_want,
                          input alu_result_type want);
      direct_row_type row;
      row.op       = op;
      row.has_want = has_want;
      row.want     = want;
      directed.push_back(row);
   endtask

   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;
   localparam logic signed [31:0] ONE  = 32'sh00010000;

   initial begin
      alu_result_type none;
      none = mk_res(0, 0, 0, 0, 0, 0, ST_OK);
      // saturation both ways on add and sub
      add_row(mk_op(FUNC_ADD, MAXV, MINV, 1, 0, 1, -1, 2, 0, 0), 1,
              mk_res(MAXV, MINV, 3, 0, 0, 0, ST_SAT));
      add_row(mk_op(FUNC_SUB, MINV, MAXV, 5, -1, 1, -1, 2, MINV, 0), 1,
              mk_res(MINV, MAXV, 3, MAXV, 0, 0, ST_SAT));
      // scale by one, by a fraction, with saturation
      add_row(mk_op(FUNC_SCALE, ONE, -ONE, MAXV, MINV, 0, 0, 0, 0, ONE), 1,
              mk_res(ONE, -ONE, MAXV, MINV, 0, 0, ST_OK));
      add_row(mk_op(FUNC_SCALE, MAXV, MINV, 3, -3, 0, 0, 0, 0, MINV), 0, none);
      add_row(mk_op(FUNC_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, 32'sh8000), 0, none);
      // divide by zero, by one, with saturation
      add_row(mk_op(FUNC_DIV, MAXV, MINV, 7, -7, 0, 0, 0, 0, 0), 1,
              mk_res(0, 0, 0, 0, 0, 0, ST_DIV0));
      add_row(mk_op(FUNC_DIV, MAXV, MINV, 7, -7, 0, 0, 0, 0, ONE), 1,
              mk_res(MAXV, MINV, 7, -7, 0, 0, ST_OK));
      add_row(mk_op(FUNC_DIV, MAXV, MINV, 7, -7, 0, 0, 0, 0, 1), 0, none);
      add_row(mk_op(FUNC_DIV, MINV, MAXV, 7, -7, 0, 0, 0, 0, -1), 0, none);
      // dot: extremes and a plain case
      add_row(mk_op(FUNC_DOT, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 0), 1,
              mk_res(0, 0, 0, 0, MAXV, 0, ST_SAT));
      add_row(mk_op(FUNC_DOT, ONE, ONE, ONE, ONE, ONE, -ONE, 2*ONE, 0, 0), 1,
              mk_res(0, 0, 0, 0, 2*ONE, 0, ST_OK));
      add_row(mk_op(FUNC_DOT, MAXV, MINV, 1, -1, MINV, MAXV, 1, 1, 0), 0, none);
      // magnitude: zero, 3-4-5, 64-bit carry out of the sum
      add_row(mk_op(FUNC_MAG, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, none);
      add_row(mk_op(FUNC_MAG, 3*ONE, 4*ONE, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_res(0, 0, 0, 0, 5*ONE, 0, ST_OK));
      add_row(mk_op(FUNC_MAG, MINV, MINV, MINV, MINV, 0, 0, 0, 0, 0), 1,
              mk_res(0, 0, 0, 0, MAXV, 0, ST_SAT));
      add_row(mk_op(FUNC_MAG, MAXV, MINV, 0, 0, 0, 0, 0, 0, 0), 0, none);
      // normalize: zero vector, tiny vector, 64-bit carry, plain
      add_row(mk_op(FUNC_NORM, 0, 0, 0, 0, 1, 2, 3, 4, 5), 1, none);
      add_row(mk_op(FUNC_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_res(ONE, 0, 0, 0, 0, 0, ST_OK));
      add_row(mk_op(FUNC_NORM, MINV, MINV, MINV, MINV, 0, 0, 0, 0, 0), 0, none);
      add_row(mk_op(FUNC_NORM, 3, -4, 0, 0, 0, 0, 0, 0, 0), 0, none);
      // equality and nearly-equal, negative epsilon never matches
      add_row(mk_op(FUNC_EQ, MAXV, MINV, 0, -1, MAXV, MINV, 0, -1, 0), 1,
              mk_res(0, 0, 0, 0, 0, 1, ST_OK));
      add_row(mk_op(FUNC_EQ, MAXV, MINV, 0, -1, MAXV, MINV, 0, 0, 0), 1, none);
      add_row(mk_op(FUNC_NEAR, MAXV, MINV, 5, 5, MINV, MAXV, 5, 5, MAXV), 1, none);
      add_row(mk_op(FUNC_NEAR, 10, 10, 10, 10, 12, 8, 10, 11, 3), 1,
              mk_res(0, 0, 0, 0, 0, 1, ST_OK));
      add_row(mk_op(FUNC_NEAR, 1, 1, 1, 1, 1, 1, 1, 1, -1), 1, none);
      // unused code
      add_row(mk_op(4'd15, MAXV, MINV, 1, 1, 1, 1, 1, 1, 1), 1, none);
   end

   // random word biased toward corners and small values
   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return MAXV;
         1:       return MINV;
         2:       return $urandom_range(0, 8) - 4;
         3, 4:    return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
         default: return $urandom;
      endcase
   endfunction

   function automatic alu_op_type rand_op();
      alu_op_type o;
      o.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
      for (int i = 0; i < 4; i++) begin
         o.a[i] = rand_word();
         // equal and nearly-equal need b close to a to hit true
         case ($urandom_range(0, 2))
            0:       o.b[i] = o.a[i];
            1:       o.b[i] = o.a[i] + $signed($urandom_range(0, 64)) - 32;
            default: o.b[i] = rand_word();
         endcase
      end
      o.s = ($urandom_range(0, 9) == 0) ? 0 : rand_word();
      if (o.func == FUNC_NEAR && $urandom_range(0, 1)) o.s = $urandom_range(0, 80) - 8;
      return o;
   endfunction

   alu_result_type typed_in [$];   // typed-in results, parallel to pending_results
   bit             typed_has [$];

   // drive one beat and hold it until it is taken
   task automatic send_op(input alu_op_type op, input bit has_want,
                          input alu_result_type want);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= op.func;
      req_ch.a_x       <= op.a[0];
      req_ch.a_y       <= op.a[1];
      req_ch.a_z       <= op.a[2];
      req_ch.a_w       <= op.a[3];
      req_ch.b_x       <= op.b[0];
      req_ch.b_y       <= op.b[1];
      req_ch.b_z       <= op.b[2];
      req_ch.b_w       <= op.b[3];
      req_ch.scalar_in <= op.s;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(predict_alu(op));
      typed_in.push_back(want);
      typed_has.push_back(has_want);
   endtask

   initial begin
      alu_result_type dummy;
      req_ch.valid     = 1'b0;
      req_ch.func      = '0;
      req_ch.a_x       = '0;
      req_ch.a_y       = '0;
      req_ch.a_z       = '0;
      req_ch.a_w       = '0;
      req_ch.b_x       = '0;
      req_ch.b_y       = '0;
      req_ch.b_z       = '0;
      req_ch.b_w       = '0;
      req_ch.scalar_in = '0;
      dummy = mk_res(0, 0, 0, 0, 0, 0, ST_OK);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_op(directed[i].op, directed[i].has_want, directed[i].want);
      for (int n = 0; n < RAND_OPS; n++) begin
         if (n == RAND_OPS - 200) calm = 1'b1;
         send_op(rand_op(), 1'b0, dummy);
      end
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: random back-pressure, compare each beat
   // ---------------------------------------------------------------------
   int stall_left = 0;

   initial rsp_ch.ready = 1'b0;

   always @(posedge clock) begin
      alu_result_type got, want;
      bit             has_typed;
      alu_result_type typed;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.vx = rsp_ch.r_x;
            got.vy = rsp_ch.r_y;
            got.vz = rsp_ch.r_z;
            got.vw = rsp_ch.r_w;
            got.scal = rsp_ch.r_scalar;
            got.flag = rsp_ch.r_flag;
            got.status = rsp_ch.r_status;
            if (pending_results.size() == 0) begin
               $display("%0t: result beat with nothing expected", $realtime);
               error_count++;
            end else begin
               want      = pending_results.pop_front();
               has_typed = typed_has.pop_front();
               typed     = typed_in.pop_front();
               // typed-in rows check the predictor as well as the block
               if (has_typed) begin
                  compare_beat("predictor", want, typed);
                  want = typed;
               end
               compare_beat("block", got, want);
            end
         end
         // bursts of stall, no new ones once the run is calm
         if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left   <= $urandom_range(0, 9);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_MAX) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
`default_nettype wire
